/* sv/tle_pkg.sv */
// Package for the terminal line editor: byte codes, control word type,
// microprogram table and dispatch decode.
// Depends on nothing; imported by tty_line_editor_top and its testbench.
package tle_pkg;

	// Terminal byte codes
	localparam logic [7:0] BYTE_ERASE_CHAR = 8'd8;
	localparam logic [7:0] BYTE_ERASE_WORD = 8'd23;
	localparam logic [7:0] BYTE_ERASE_LINE = 8'd24;
	localparam logic [7:0] BYTE_REDRAW     = 8'd18;
	localparam logic [7:0] BYTE_CR         = 8'd13;
	localparam logic [7:0] BYTE_LF         = 8'd10;
	localparam logic [7:0] BYTE_BS         = 8'd8;
	localparam logic [7:0] BYTE_SPACE      = 8'd32;
	localparam logic [7:0] BYTE_CARET      = 8'd94;
	localparam logic [7:0] BYTE_R          = 8'd82;

	// Register map
	localparam logic REG_MODE = 1'b0;
	localparam logic MODE_RAW = 1'b1;

	// Output channel tags
	localparam logic CHAN_ECHO = 1'b0;
	localparam logic CHAN_LINE = 1'b1;

	typedef logic [4:0] pc_t;

	typedef enum logic [2:0] {
		EM_NONE, EM_LF, EM_BS, EM_SP, EM_CARET, EM_R, EM_CHAR, EM_STORE
	} emit_t;

	typedef enum logic [1:0] {AP_NONE, AP_CR, AP_LF, AP_CHAR} app_t;
	typedef enum logic [1:0] {FL_KEEP, FL_DEC, FL_CLR} fill_op_t;
	typedef enum logic [1:0] {IX_KEEP, IX_CLR, IX_INC} idx_op_t;

	typedef enum logic [2:0] {
		C_NEVER, C_ALWAYS, C_EMPTY, C_IDX_DONE, C_TOP_SP, C_TOP_NSP, C_NOT_FULL
	} cond_t;

	typedef struct packed {
		emit_t    emit;
		logic     chan;
		app_t     app;
		fill_op_t fill;
		idx_op_t  idx;
		cond_t    cond;
		pc_t      target;
		logic     fin;
	} ctrl_word_t;

	localparam ctrl_word_t CW_NOP = '{EM_NONE, CHAN_ECHO, AP_NONE, FL_KEEP,
		IX_KEEP, C_NEVER, 5'd0, 1'b0};

	// Program entry points and loop heads
	localparam pc_t A_RAW  = 5'd0;
	localparam pc_t A_NL   = 5'd1;
	localparam pc_t A_ECH  = 5'd3;
	localparam pc_t A_ELN  = 5'd7;
	localparam pc_t A_EW1  = 5'd11;
	localparam pc_t A_EW2  = 5'd16;
	localparam pc_t A_RDR  = 5'd21;
	localparam pc_t A_RLP  = 5'd24;
	localparam pc_t A_DEF  = 5'd26;
	localparam pc_t A_DLV  = 5'd28;
	localparam pc_t A_DEND = 5'd30;
	localparam pc_t A_FIN  = 5'd31;

	// Entry point for a newly accepted byte
	function automatic pc_t entry_pc(input logic mode, input logic [7:0] c);
		pc_t p;
		if (mode == MODE_RAW) begin
			p = A_RAW;
		end else begin
			case (c)
				BYTE_CR, BYTE_LF: p = A_NL;
				BYTE_ERASE_CHAR:  p = A_ECH;
				BYTE_ERASE_WORD:  p = A_EW1;
				BYTE_ERASE_LINE:  p = A_ELN;
				BYTE_REDRAW:      p = A_RDR;
				default:          p = A_DEF;
			endcase
		end
		return p;
	endfunction

	// Microprogram: jump to target when cond holds, else fall through
	function automatic ctrl_word_t rom(input pc_t pc);
		ctrl_word_t w;
		w = CW_NOP;
		case (pc)
			// raw: append typed byte, deliver
			5'd0: begin
				w.app = AP_CHAR; w.idx = IX_CLR; w.cond = C_ALWAYS; w.target = A_DLV;
			end
			// CR/LF: append CR LF, echo LF, deliver
			5'd1: begin
				w.app = AP_CR; w.idx = IX_CLR;
			end
			5'd2: begin
				w.app = AP_LF; w.emit = EM_LF; w.cond = C_ALWAYS; w.target = A_DLV;
			end
			// erase one character
			5'd3: begin
				w.cond = C_EMPTY; w.target = A_FIN;
			end
			5'd4: begin
				w.emit = EM_BS; w.fill = FL_DEC;
			end
			5'd5: w.emit = EM_SP;
			5'd6: begin
				w.emit = EM_BS; w.cond = C_ALWAYS; w.target = A_FIN;
			end
			// erase whole line
			5'd7: begin
				w.cond = C_EMPTY; w.target = A_FIN;
			end
			5'd8: begin
				w.emit = EM_BS; w.fill = FL_DEC;
			end
			5'd9: w.emit = EM_SP;
			5'd10: begin
				w.emit = EM_BS; w.cond = C_ALWAYS; w.target = A_ELN;
			end
			// erase word, trailing spaces first
			5'd11: begin
				w.cond = C_EMPTY; w.target = A_FIN;
			end
			5'd12: begin
				w.cond = C_TOP_NSP; w.target = A_EW2;
			end
			5'd13: begin
				w.emit = EM_BS; w.fill = FL_DEC;
			end
			5'd14: w.emit = EM_SP;
			5'd15: begin
				w.emit = EM_BS; w.cond = C_ALWAYS; w.target = A_EW1;
			end
			// erase word, the non-space run
			5'd16: begin
				w.cond = C_EMPTY; w.target = A_FIN;
			end
			5'd17: begin
				w.cond = C_TOP_SP; w.target = A_FIN;
			end
			5'd18: begin
				w.emit = EM_BS; w.fill = FL_DEC;
			end
			5'd19: w.emit = EM_SP;
			5'd20: begin
				w.emit = EM_BS; w.cond = C_ALWAYS; w.target = A_EW2;
			end
			// redraw: ^R LF then the held bytes as echo
			5'd21: begin
				w.emit = EM_CARET; w.idx = IX_CLR;
			end
			5'd22: w.emit = EM_R;
			5'd23: w.emit = EM_LF;
			5'd24: begin
				w.cond = C_IDX_DONE; w.target = A_FIN;
			end
			5'd25: begin
				w.emit = EM_STORE; w.idx = IX_INC; w.cond = C_ALWAYS; w.target = A_RLP;
			end
			// ordinary byte: store, echo, deliver once fill reaches LINE_SIZE - 1
			5'd26: begin
				w.app = AP_CHAR; w.emit = EM_CHAR; w.idx = IX_CLR;
			end
			5'd27: begin
				w.cond = C_NOT_FULL; w.target = A_FIN;
			end
			// deliver loop
			5'd28: begin
				w.cond = C_IDX_DONE; w.target = A_DEND;
			end
			5'd29: begin
				w.emit = EM_STORE; w.chan = CHAN_LINE; w.idx = IX_INC;
				w.cond = C_ALWAYS; w.target = A_DLV;
			end
			5'd30: begin
				w.fill = FL_CLR; w.fin = 1'b1;
			end
			5'd31: w.fin = 1'b1;
			default: w = CW_NOP;
		endcase
		return w;
	endfunction

endpackage

/* sv/tty_line_editor_top.sv */
// Top level of the terminal line editor: microcoded sequencer, line
// register array, result lookahead and output register.
// Depends on tle_pkg.
//
// Usage: typed bytes enter on the s_ stream (s_tdata), one word per byte.
// Results leave on the m_ stream: m_tdata is the byte, m_tuser the channel
// (0 echo to terminal, 1 byte of a delivered line), m_tlast marks the final
// result caused by one typed byte. Bytes that cause nothing produce no word.
// The APB port holds one register, mode (0 cooked, 1 raw), where paddr[2] = 0.
// Timing: one byte is processed at a time; s_tready is low while its program
// runs. The sequencer executes one control word per cycle unless stalled on
// the output: each result word costs one step, each loop test one more, plus
// a finish step. Results follow at up to one per cycle while the receiver
// keeps up, fewer during a delivery, where a loop test precedes each byte.
// A one-word lookahead holds each result until the next result or the finish
// step shows whether it is last.
// Stall: when the output register is full and m_tready is low, the sequencer
// freezes on its next step that must push the held result (an emitting or
// finish step); nothing is dropped. Reset clears the fill count, mode and all
// control state; line bytes are not cleared and only written ones are read.
module tty_line_editor_top #(
	parameter int LINE_SIZE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// typed byte stream; s_tdata[7:0] = typed_byte
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// result stream; m_tdata[7:0] = data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	// m_tuser[0] = channel
	output logic        m_tuser,
	output logic        m_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tle_pkg::*;

	localparam int IW = $clog2(LINE_SIZE);
	localparam int FW = $clog2(LINE_SIZE + 1);
	localparam logic [FW-1:0] FILL_LIMIT = FW'(LINE_SIZE);
	localparam logic [FW-1:0] FULL_MARK  = FW'(LINE_SIZE - 1);

	logic            mode_q;
	logic            busy_q;
	pc_t             pc_q;
	logic [7:0]      char_q;
	logic [FW-1:0]   fill_q;
	logic [FW-1:0]   idx_q;
	logic [7:0]      line_q [LINE_SIZE];

	logic            pend_valid_q;
	logic            pend_chan_q;
	logic [7:0]      pend_byte_q;
	logic            out_valid_q;
	logic            out_chan_q;
	logic [7:0]      out_byte_q;
	logic            out_last_q;

	ctrl_word_t      cw;
	logic [IW-1:0]   rd_addr;
	logic [7:0]      rd_byte;
	logic [7:0]      emit_byte;
	logic [7:0]      app_byte;
	logic            take;
	logic            gen;
	logic            need_push;
	logic            out_ok;
	logic            adv;
	pc_t             pc_next;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = {31'd0, mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MODE) begin
			mode_q <= pwdata[0];
		end
	end

	// Control word and datapath selection
	assign cw = rom(pc_q);
	assign rd_addr = (cw.cond == C_TOP_SP || cw.cond == C_TOP_NSP) ?
		IW'(fill_q - FW'(1)) : idx_q[IW-1:0];
	assign rd_byte = line_q[rd_addr];

	always_comb begin
		case (cw.emit)
			EM_LF:    emit_byte = BYTE_LF;
			EM_BS:    emit_byte = BYTE_BS;
			EM_SP:    emit_byte = BYTE_SPACE;
			EM_CARET: emit_byte = BYTE_CARET;
			EM_R:     emit_byte = BYTE_R;
			EM_CHAR:  emit_byte = char_q;
			EM_STORE: emit_byte = rd_byte;
			default:  emit_byte = 8'd0;
		endcase
	end

	always_comb begin
		case (cw.app)
			AP_CR:   app_byte = BYTE_CR;
			AP_LF:   app_byte = BYTE_LF;
			default: app_byte = char_q;
		endcase
	end

	// Jump condition
	always_comb begin
		case (cw.cond)
			C_ALWAYS:   take = 1'b1;
			C_EMPTY:    take = (fill_q == '0);
			C_IDX_DONE: take = (idx_q >= fill_q);
			C_TOP_SP:   take = (rd_byte == BYTE_SPACE);
			C_TOP_NSP:  take = (rd_byte != BYTE_SPACE);
			C_NOT_FULL: take = (fill_q < FULL_MARK);
			default:    take = 1'b0;
		endcase
	end

	// Step advance: a step that must push the held result waits for the output
	assign gen       = busy_q && (cw.emit != EM_NONE);
	assign need_push = pend_valid_q && (gen || cw.fin);
	assign out_ok    = !out_valid_q || m_tready;
	assign adv       = busy_q && (!need_push || out_ok);
	assign pc_next   = take ? cw.target : pc_q + pc_t'(1);
	assign s_tready  = !busy_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= A_FIN;
		end else if (s_tvalid && s_tready) begin
			busy_q <= 1'b1;
			pc_q   <= entry_pc(mode_q, s_tdata);
		end else if (adv) begin
			if (cw.fin) begin
				busy_q <= 1'b0;
			end
			pc_q <= pc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_q <= s_tdata;
		end
	end

	// Fill count and index counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			idx_q  <= '0;
		end else if (adv) begin
			if (cw.fill == FL_CLR) begin
				fill_q <= '0;
			end else if (cw.fill == FL_DEC) begin
				fill_q <= fill_q - FW'(1);
			end else if (cw.app != AP_NONE && fill_q < FILL_LIMIT) begin
				fill_q <= fill_q + FW'(1);
			end
			if (cw.idx == IX_CLR) begin
				idx_q <= '0;
			end else if (cw.idx == IX_INC) begin
				idx_q <= idx_q + FW'(1);
			end
		end
	end

	// Line register array
	always_ff @(posedge clk) begin
		if (adv && cw.app != AP_NONE && fill_q < FILL_LIMIT) begin
			line_q[fill_q[IW-1:0]] <= app_byte;
		end
	end

	// Lookahead word: pushed out when the next result or the finish arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (adv) begin
			if (gen) begin
				pend_valid_q <= 1'b1;
			end else if (cw.fin) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && gen) begin
			pend_chan_q <= cw.chan;
			pend_byte_q <= emit_byte;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && need_push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && need_push) begin
			out_chan_q <= pend_chan_q;
			out_byte_q <= pend_byte_q;
			out_last_q <= cw.fin;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_chan_q;
	assign m_tlast  = out_last_q;

	// Checks
	a_idle_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> fill_q <= FW'(LINE_SIZE - 2))
		else $error("fill count above line limit while idle");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !pend_valid_q)
		else $error("lookahead word left over after finish");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> busy_q && !pend_valid_q)
		else $error("program did not start cleanly");

	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cw.fin) |=> !busy_q)
		else $error("finish step did not release input");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && need_push && !out_ok) |=> $stable(pc_q) && $stable(fill_q))
		else $error("sequencer moved while output stalled");

endmodule

/* tb/sv/tb_tty_line_editor_top.sv */
// Self-checking testbench for tty_line_editor_top: typed bytes go in on the
// input stream, echo and line bytes are predicted and checked on the output.
// Depends on tle_pkg and tty_line_editor_top.
module tb_tty_line_editor_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tle_pkg::*;

	localparam int LINE_SIZE      = 16;
	localparam int CLK_PERIOD     = 12;
	localparam int QUIET_CYCLES   = 80;
	localparam int STALL_CYCLES   = 300;
	localparam int TIMEOUT_CYCLES = 500_000;
	localparam logic MODE_COOKED  = 1'b0;
	localparam logic [2:0] MODE_ADDR = {REG_MODE, 2'b00};

	// one output word: channel, byte, last flag
	typedef struct packed {
		logic       chan;
		logic [7:0] data;
		logic       last;
	} editor_word_t;

	// Line discipline predictor and expected output store
	class editor_scoreboard;
		logic [7:0]   line_buf [LINE_SIZE];
		int           fill;
		logic         raw_mode;
		editor_word_t staged[$];
		editor_word_t expected_words[$];
		int           errors;
		int           cooked_count;
		int           raw_count;
		int           checked_count;

		function new();
			fill = 0;
			raw_mode = MODE_COOKED;
			errors = 0;
			cooked_count = 0;
			raw_count = 0;
			checked_count = 0;
		endfunction

		function void set_mode(logic m);
			raw_mode = m;
		endfunction

		function void stage(logic chan, logic [7:0] data);
			editor_word_t w;
			w.chan = chan;
			w.data = data;
			w.last = 1'b0;
			staged.push_back(w);
		endfunction

		function void store_byte(logic [7:0] c);
			if (fill < LINE_SIZE) begin
				line_buf[fill] = c;
				fill++;
			end
		endfunction

		// erase one held char: BS, space, BS
		function void rub_out();
			fill--;
			stage(CHAN_ECHO, BYTE_BS);
			stage(CHAN_ECHO, BYTE_SPACE);
			stage(CHAN_ECHO, BYTE_BS);
		endfunction

		function void deliver_line();
			for (int i = 0; i < fill; i++)
				stage(CHAN_LINE, line_buf[i]);
			fill = 0;
		endfunction

		// predict all output words caused by one accepted typed byte
		function void note_typed_byte(logic [7:0] c);
			editor_word_t w;
			if (raw_mode == MODE_RAW) begin
				raw_count++;
				store_byte(c);
				deliver_line();
			end else begin
				cooked_count++;
				case (c)
					BYTE_CR, BYTE_LF: begin
						store_byte(BYTE_CR);
						store_byte(BYTE_LF);
						stage(CHAN_ECHO, BYTE_LF);
						deliver_line();
					end
					BYTE_ERASE_CHAR: begin
						if (fill > 0)
							rub_out();
					end
					BYTE_ERASE_WORD: begin
						while (fill > 0 && line_buf[fill-1] == BYTE_SPACE)
							rub_out();
						while (fill > 0 && line_buf[fill-1] != BYTE_SPACE)
							rub_out();
					end
					BYTE_ERASE_LINE: begin
						while (fill > 0)
							rub_out();
					end
					BYTE_REDRAW: begin
						stage(CHAN_ECHO, BYTE_CARET);
						stage(CHAN_ECHO, BYTE_R);
						stage(CHAN_ECHO, BYTE_LF);
						for (int i = 0; i < fill; i++)
							stage(CHAN_ECHO, line_buf[i]);
					end
					default: begin
						store_byte(c);
						stage(CHAN_ECHO, c);
						if (fill >= LINE_SIZE - 1)
							deliver_line();
					end
				endcase
			end
			// last flag on the final word of this byte
			foreach (staged[k]) begin
				w = staged[k];
				w.last = (k == staged.size() - 1);
				expected_words.push_back(w);
			end
			staged.delete();
		endfunction

		function void check_output_word(logic chan, logic [7:0] data, logic last);
			editor_word_t w;
			if (expected_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, got chan %0d byte 0x%02h last %0d",
					$time, chan, data, last);
			end else begin
				w = expected_words.pop_front();
				checked_count++;
				if (chan !== w.chan) begin
					errors++;
					$display("%0t: channel mismatch, expected %0d, got %0d",
						$time, w.chan, chan);
				end
				if (data !== w.data) begin
					errors++;
					$display("%0t: byte mismatch, expected 0x%02h, got 0x%02h",
						$time, w.data, data);
				end
				if (last !== w.last) begin
					errors++;
					$display("%0t: last mismatch, expected %0d, got %0d",
						$time, w.last, last);
				end
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = 3'd0;
	logic [31:0] pwdata   = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	editor_scoreboard sb = new();

	int snd_idle_pct  = 19;
	int rcv_idle_pct  = 64;
	bit stall_request = 1'b0;
	bit stall_taken   = 1'b0;
	int stall_left    = 0;
	int mode_writes   = 0;

	tty_line_editor_top #(
		.LINE_SIZE(LINE_SIZE)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#(CLK_PERIOD/2);
		clk = 1'b1;
		#(CLK_PERIOD/2);
	end

	// receiver: random back-pressure, plus one long hold-off on request
	always @(negedge clk) begin
		if (stall_request && !stall_taken) begin
			stall_taken = 1'b1;
			stall_left = STALL_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// monitors: check output words, then note accepted input words
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_output_word(m_tuser, m_tdata, m_tlast);
		if (s_tvalid && s_tready)
			sb.note_typed_byte(s_tdata);
	end

	// offer one typed byte, with random idle cycles ahead of it
	task automatic type_byte(input logic [7:0] b);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// drain all expected words, then give the sequencer time to finish
	task automatic wait_editor_quiet();
		s_tvalid <= 1'b0;
		while (sb.expected_words.size() != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	// APB write of the mode register: setup then access
	task automatic set_line_mode(input logic m);
		logic [31:0] v;
		v = $urandom();
		v[0] = m;
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= MODE_ADDR;
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_mode(m);
		mode_writes++;
	endtask

	// a run of words and spaces closed by a random control byte or by none, or noise
	task automatic type_line_burst(output int sent);
		int len;
		int op;
		logic [7:0] ch;
		sent = 0;
		if ($urandom_range(99) < 15) begin
			type_byte(8'($urandom_range(255)));
			sent = 1;
		end else begin
			len = ($urandom_range(3) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				ch = ($urandom_range(3) == 0) ? BYTE_SPACE : 8'($urandom_range(33, 126));
				type_byte(ch);
			end
			sent = len;
			op = $urandom_range(6);
			case (op)
				0: type_byte(BYTE_CR);
				1: type_byte(BYTE_LF);
				2: type_byte(BYTE_ERASE_CHAR);
				3: type_byte(BYTE_ERASE_WORD);
				4: type_byte(BYTE_ERASE_LINE);
				5: type_byte(BYTE_REDRAW);
				default: ;
			endcase
			if (op != 6)
				sent++;
		end
	endtask

	// stimulus
	initial begin
		logic [7:0] cooked_script [22];
		logic [7:0] raw_script [3];
		int sent;
		int n;
		cooked_script = '{BYTE_ERASE_CHAR, BYTE_ERASE_WORD, BYTE_ERASE_LINE, BYTE_REDRAW,
			8'h00, 8'hFF, "a", BYTE_SPACE, BYTE_ERASE_WORD,
			"x", BYTE_SPACE, "y", BYTE_SPACE, BYTE_SPACE, BYTE_REDRAW,
			BYTE_ERASE_WORD, BYTE_ERASE_CHAR, BYTE_CR,
			"q", BYTE_ERASE_LINE, BYTE_LF, "k"};
		raw_script = '{8'hFF, 8'h00, BYTE_CR};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty-buffer controls, extremes, word erase, redraw
		set_line_mode(MODE_COOKED);
		foreach (cooked_script[i])
			type_byte(cooked_script[i]);
		// raw with a held byte left over from cooked mode
		wait_editor_quiet();
		set_line_mode(MODE_RAW);
		foreach (raw_script[i])
			type_byte(raw_script[i]);

		// random: three idle profiles, cooked then raw in each
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					snd_idle_pct = 19;
					rcv_idle_pct = 64;
				end
				1: begin
					snd_idle_pct = 64;
					rcv_idle_pct = 19;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			wait_editor_quiet();
			set_line_mode(MODE_COOKED);
			if (p == 2)
				stall_request = 1'b1;
			sent = 0;
			while (sent < 30) begin
				type_line_burst(n);
				sent += n;
			end
			wait_editor_quiet();
			set_line_mode(MODE_RAW);
			repeat (12) type_byte(8'($urandom_range(255)));
		end

		wait_editor_quiet();
		$display("Typed %0d cooked and %0d raw bytes across %0d mode writes,",
			sb.cooked_count, sb.raw_count, mode_writes);
		$display("checked %0d output words under three back-pressure profiles and a long stall.",
			sb.checked_count);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Timeout with %0d words still expected", sb.expected_words.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
